@@ rtl/mdr_pkg.sv @@
// Shared constants, types and helper functions of the dimension merge index remap unit.
package mdr_pkg;

	localparam int MAX_DIMS      = 4;
	localparam int DIM_BITS      = 12;
	localparam int IDX_BITS      = 48;
	localparam int DIM_IDX_BITS  = 2;
	localparam int NUM_DIMS_BITS = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = DIM_BITS;
	localparam int NUM_DIVS      = MAX_DIMS - 1;
	localparam int NUM_DIV_CELLS = NUM_DIVS * IDX_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_DIMS   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIM_SIZE_0 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REDUCE_DIM = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_GROW_DIM   = 3'd6;

	typedef logic [DIM_BITS-1:0]                      dim_t;
	typedef logic [IDX_BITS-1:0]                      idx_t;
	typedef logic [DIM_IDX_BITS-1:0]                  dsel_t;
	typedef logic [MAX_DIMS-1:0][DIM_BITS-1:0]        dim_vec_t;
	typedef logic [MAX_DIMS-1:0][DIM_IDX_BITS-1:0]    dim_ord_t;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_RANGE  = 2'd1,
		ERR_CONFIG = 2'd2
	} err_t;

	// Item inside the divider chain: running quotient, partial remainder, coordinates so far.
	typedef struct packed {
		idx_t     quo;
		dim_t     rem;
		dim_vec_t coord;
	} div_item_t;

	// Item inside the recomposition chain.
	typedef struct packed {
		idx_t     acc;
		dim_vec_t coord;
		err_t     err;
	} mac_item_t;

	// Output dimension order: the reduce dimension sits right before the grow dimension.
	// Folding it there gives grow + reduce * size_of_grow under a size of the product.
	function automatic dim_ord_t merge_order(input dsel_t reduce, input dsel_t grow);
		dim_ord_t o;
		int       k;
		o = '0;
		k = 0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (DIM_IDX_BITS'(i) == grow) begin
				if (k < MAX_DIMS) o[k] = reduce;
				k++;
				if (k < MAX_DIMS) o[k] = grow;
				k++;
			end else if (DIM_IDX_BITS'(i) != reduce) begin
				if (k < MAX_DIMS) o[k] = DIM_IDX_BITS'(i);
				k++;
			end
		end
		return o;
	endfunction

endpackage

@@ rtl/mdr_ifs.sv @@
// Channel interfaces: index requests, remapped results and configuration writes.
interface mdr_req_if import mdr_pkg::*; ();
	logic valid;
	logic ready;
	idx_t in_index;
	modport source (output valid, output in_index, input ready);
	modport sink   (input valid, input in_index, output ready);
endinterface

interface mdr_rsp_if import mdr_pkg::*; ();
	logic valid;
	logic ready;
	idx_t out_index;
	err_t error_code;
	modport source (output valid, output out_index, output error_code, input ready);
	modport sink   (input valid, input out_index, input error_code, output ready);
endinterface

interface mdr_cfg_if import mdr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mdr_div_cell.sv @@
// One restoring division step: produces one quotient bit and hands the item on.
module mdr_div_cell import mdr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  dim_t      divisor,
	input  logic      in_valid,
	input  div_item_t in_item,
	output logic      valid_q,
	output div_item_t item_q
);

	logic [DIM_BITS:0] trial;
	logic              ge;
	div_item_t         nxt;

	always_comb begin
		trial = {in_item.rem, in_item.quo[IDX_BITS-1]};
		ge    = trial >= {1'b0, divisor};
		nxt   = in_item;
		nxt.quo = {in_item.quo[IDX_BITS-2:0], ge};
		// The partial remainder stays below the divisor, so the difference fits.
		nxt.rem = ge ? DIM_BITS'(trial - {1'b0, divisor}) : trial[DIM_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

endmodule

@@ rtl/mdr_mac_cell.sv @@
// One Horner step of the output index: acc * size + coord.
module mdr_mac_cell import mdr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  dim_t      size,
	input  dim_t      coord,
	input  logic      in_valid,
	input  mac_item_t in_item,
	output logic      valid_q,
	output mac_item_t item_q
);

	logic [IDX_BITS+DIM_BITS-1:0] prod;
	mac_item_t                    nxt;

	always_comb begin
		prod    = in_item.acc * size;
		nxt     = in_item;
		nxt.acc = prod[IDX_BITS-1:0] + IDX_BITS'(coord);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

endmodule

@@ rtl/merge_dimensions_index_remap_unit.sv @@
// Top level of the dimension merge index remap unit.
//
//   channel  direction  payload                    notes
//   req      in         in_index[47:0]             linear index in the input array
//   rsp      out        out_index[47:0], error     linear index in the merged array
//   cfg      in         index[2:0], data[11:0]     register writes, always ready
//
// One index enters per cycle while the chain is not stalled; each result passes 144 divider
// cells (one quotient bit per cell, 48 per divided dimension) and 4 Horner cells.
// The whole chain advances together; it holds while a result waits on rsp, and
// req is ready whenever the last cell is empty or rsp is taken.
// Reset clears the valid bits and loads the reset configuration.
module merge_dimensions_index_remap_unit import mdr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	mdr_req_if.sink   req,
	mdr_rsp_if.source rsp,
	mdr_cfg_if.sink   cfg
);

	logic [NUM_DIMS_BITS-1:0] num_dims_q;
	dim_vec_t                 size_q;
	dsel_t                    reduce_q;
	dsel_t                    grow_q;

	dim_vec_t eff_size;
	dim_ord_t order;
	logic     cfg_bad;
	logic     any_zero;
	logic     en;

	div_item_t div_q [NUM_DIV_CELLS];
	logic      div_vq[NUM_DIV_CELLS];
	mac_item_t mac_q [MAX_DIMS];
	logic      mac_vq[MAX_DIMS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= NUM_DIMS_BITS'(3);
			size_q     <= {MAX_DIMS{DIM_BITS'(1)}};
			reduce_q   <= DIM_IDX_BITS'(0);
			grow_q     <= DIM_IDX_BITS'(1);
		end else if (cfg.valid) begin
			if (cfg.index == REG_NUM_DIMS) begin
				num_dims_q <= cfg.data[NUM_DIMS_BITS-1:0];
			end else if (cfg.index == REG_REDUCE_DIM) begin
				reduce_q <= cfg.data[DIM_IDX_BITS-1:0];
			end else if (cfg.index == REG_GROW_DIM) begin
				grow_q <= cfg.data[DIM_IDX_BITS-1:0];
			end else if (cfg.index >= REG_DIM_SIZE_0 &&
			             cfg.index < REG_DIM_SIZE_0 + CFG_IDX_BITS'(MAX_DIMS)) begin
				size_q[DIM_IDX_BITS'(cfg.index - REG_DIM_SIZE_0)] <= cfg.data;
			end
		end
	end

	// Dimensions that are not in use act as size one, so they add a zero coordinate.
	always_comb begin
		any_zero = 1'b0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			eff_size[i] = (int'(num_dims_q) > i) ? size_q[i] : DIM_BITS'(1);
			any_zero    = any_zero | (eff_size[i] == '0);
		end
	end

	assign cfg_bad = (num_dims_q < NUM_DIMS_BITS'(2)) ||
	                 (num_dims_q > NUM_DIMS_BITS'(MAX_DIMS)) ||
	                 (reduce_q == grow_q) ||
	                 ({1'b0, reduce_q} >= num_dims_q) ||
	                 ({1'b0, grow_q} >= num_dims_q);

	assign order = merge_order(reduce_q, grow_q);

	assign en        = !mac_vq[MAX_DIMS-1] || rsp.ready;
	assign req.ready = en;

	// Divider chain: the fastest dimension is divided out first.
	for (genvar k = 0; k < NUM_DIV_CELLS; k++) begin : g_div
		localparam int D   = k / IDX_BITS;
		localparam int B   = k % IDX_BITS;
		localparam int DIM = MAX_DIMS - 1 - D;
		div_item_t d_in;
		logic      v_in;

		if (k == 0) begin : g_head
			always_comb begin
				d_in.quo   = req.in_index;
				d_in.rem   = '0;
				d_in.coord = '0;
			end
			assign v_in = req.valid;
		end else if (B == 0) begin : g_start
			// A new division starts; the finished remainder is the previous coordinate.
			always_comb begin
				d_in              = div_q[k-1];
				d_in.rem          = '0;
				d_in.coord[DIM+1] = div_q[k-1].rem;
			end
			assign v_in = div_vq[k-1];
		end else begin : g_step
			assign d_in = div_q[k-1];
			assign v_in = div_vq[k-1];
		end

		mdr_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.divisor (eff_size[DIM]),
			.in_valid(v_in),
			.in_item (d_in),
			.valid_q (div_vq[k]),
			.item_q  (div_q[k])
		);
	end

	// The quotient left after all divisions is the slowest coordinate; it must fit its size.
	mac_item_t chk_item;
	logic      range_bad;

	always_comb begin
		range_bad = (|div_q[NUM_DIV_CELLS-1].quo[IDX_BITS-1:DIM_BITS]) ||
		            (div_q[NUM_DIV_CELLS-1].quo[DIM_BITS-1:0] >= eff_size[0]) ||
		            any_zero;
		chk_item.acc      = '0;
		chk_item.coord    = div_q[NUM_DIV_CELLS-1].coord;
		chk_item.coord[1] = div_q[NUM_DIV_CELLS-1].rem;
		chk_item.coord[0] = div_q[NUM_DIV_CELLS-1].quo[DIM_BITS-1:0];
		if (cfg_bad) begin
			chk_item.err = ERR_CONFIG;
		end else if (range_bad) begin
			chk_item.err = ERR_RANGE;
		end else begin
			chk_item.err = ERR_OK;
		end
	end

	for (genvar j = 0; j < MAX_DIMS; j++) begin : g_mac
		mac_item_t m_in;
		logic      v_in;

		if (j == 0) begin : g_first
			assign m_in = chk_item;
			assign v_in = div_vq[NUM_DIV_CELLS-1];
		end else begin : g_next
			assign m_in = mac_q[j-1];
			assign v_in = mac_vq[j-1];
		end

		mdr_mac_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.size    (eff_size[order[j]]),
			.coord   (m_in.coord[order[j]]),
			.in_valid(v_in),
			.in_item (m_in),
			.valid_q (mac_vq[j]),
			.item_q  (mac_q[j])
		);
	end

	assign rsp.valid      = mac_vq[MAX_DIMS-1];
	assign rsp.error_code = mac_q[MAX_DIMS-1].err;
	assign rsp.out_index  = (mac_q[MAX_DIMS-1].err == ERR_OK) ? mac_q[MAX_DIMS-1].acc : '0;

endmodule

@@ rtl/mdr_checker.sv @@
// Port-level checks of the dimension merge index remap unit, bound to the top level.
module mdr_checker import mdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input idx_t out_index,
	input err_t error_code,
	input logic cfg_ready
);

	// A result with an error carries a zero index.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error_code != ERR_OK |-> out_index == '0)
		else $error("error result with nonzero out_index");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_index) && $stable(error_code))
		else $error("stalled result changed");

	// While the last result is held, no new request enters the chain.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request accepted while chain stalled");

	// The configuration port never pushes back.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind merge_dimensions_index_remap_unit mdr_checker u_mdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_index (rsp.out_index),
	.error_code(rsp.error_code),
	.cfg_ready (cfg.ready)
);

@@ tb/sv/merge_dimensions_index_remap_unit_tb.sv @@
// Testbench of the dimension merge index remap unit: random and directed index requests.
`timescale 1ns / 100ps

module merge_dimensions_index_remap_unit_tb;
	import mdr_pkg::*;

	localparam int LATENCY     = 148;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		idx_t out_index;
		err_t error_code;
	} remap_t;

	// Keeps the shadow configuration and the queue of predicted remapped indexes.
	class remap_scoreboard;
		logic [2:0] num_dims;
		dim_t       sizes [MAX_DIMS];
		dsel_t      reduce_sel;
		dsel_t      grow_sel;
		remap_t     pending [$];
		int         errors;
		int         checked;

		function void reset_regs();
			num_dims = 3'd3;
			foreach (sizes[k]) sizes[k] = 12'd1;
			reduce_sel = 2'd0;
			grow_sel = 2'd1;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] index, dim_t data);
			if (index == REG_NUM_DIMS) num_dims = data[2:0];
			else if (index == REG_REDUCE_DIM) reduce_sel = data[1:0];
			else if (index == REG_GROW_DIM) grow_sel = data[1:0];
			else if (index >= REG_DIM_SIZE_0 && index < REG_DIM_SIZE_0 + MAX_DIMS)
				sizes[index - REG_DIM_SIZE_0] = data;
		endfunction

		function remap_t remap(idx_t in_index);
			remap_t r;
			logic [63:0] total, rem, acc, c, sz;
			logic [63:0] coord [MAX_DIMS];
			int n;
			r.out_index = '0;
			n = num_dims;
			if (num_dims < 2 || num_dims > MAX_DIMS || reduce_sel == grow_sel
					|| reduce_sel >= num_dims || grow_sel >= num_dims) begin
				r.error_code = ERR_CONFIG;
				return r;
			end
			total = 1;
			for (int i = 0; i < n; i++) total = total * sizes[i];
			if (in_index >= total) begin
				r.error_code = ERR_RANGE;
				return r;
			end
			rem = in_index;
			for (int i = n - 1; i >= 0; i--) begin
				coord[i] = rem % sizes[i];
				rem = rem / sizes[i];
			end
			acc = 0;
			for (int i = 0; i < n; i++) begin
				if (i == reduce_sel) continue;
				if (i == grow_sel) begin
					c = coord[i] + coord[reduce_sel] * sizes[i];
					sz = sizes[i] * sizes[reduce_sel];
				end else begin
					c = coord[i];
					sz = sizes[i];
				end
				acc = acc * sz + c;
			end
			r.out_index = acc[IDX_BITS-1:0];
			r.error_code = ERR_OK;
			return r;
		endfunction

		function void note_request(idx_t in_index);
			pending.push_back(remap(in_index));
		endfunction

		function void check_result(idx_t out_index, err_t error_code);
			remap_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("result with nothing pending: out_index %0h", out_index);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (out_index !== e.out_index) begin
				$error("out_index: expected %0h, actual %0h", e.out_index, out_index);
				errors++;
			end
			if (error_code !== e.error_code) begin
				$error("error_code: expected %0d, actual %0d", e.error_code, error_code);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	mdr_req_if req ();
	mdr_rsp_if rsp ();
	mdr_cfg_if cfg ();

	merge_dimensions_index_remap_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	remap_scoreboard sb;
	bit calm;            // no idling on either side while set
	int idle_count = 0;
	int phases;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		sb = new();
		sb.reset_regs();
	end

	always @(posedge clk) begin
		if (req.valid && req.ready) sb.note_request(req.in_index);
		if (rsp.valid && rsp.ready) sb.check_result(rsp.out_index, rsp.error_code);
	end

	// Result side stalls at random unless in a calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= calm || ($urandom_range(99) >= 24);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("merge_dimensions_index_remap_unit_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] index, dim_t data);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(index, data);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_shape(logic [2:0] n, dim_t s0, dim_t s1, dim_t s2, dim_t s3,
			dsel_t red, dsel_t grw);
		write_reg(REG_NUM_DIMS, dim_t'(n));
		write_reg(REG_DIM_SIZE_0, s0);
		write_reg(REG_DIM_SIZE_0 + 3'd1, s1);
		write_reg(REG_DIM_SIZE_0 + 3'd2, s2);
		write_reg(REG_DIM_SIZE_0 + 3'd3, s3);
		write_reg(REG_REDUCE_DIM, dim_t'(red));
		write_reg(REG_GROW_DIM, dim_t'(grw));
		phases++;
	endtask

	// Leaves valid high after the handshake; drain() lowers it at the end of a burst.
	task automatic send_index(idx_t value);
		while (!calm && $urandom_range(99) < 24) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.in_index <= value;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic [63:0] element_count();
		logic [63:0] t;
		t = 1;
		for (int i = 0; i < sb.num_dims && i < MAX_DIMS; i++) t = t * sb.sizes[i];
		return t;
	endfunction

	// Mostly in-range indexes, some just past the end, some anywhere.
	function automatic idx_t pick_index();
		logic [63:0] t;
		int p;
		t = element_count();
		p = $urandom_range(99);
		if (p < 75 && t != 0) return idx_t'({$urandom, $urandom} % t);
		if (p < 88) return idx_t'(t + $urandom_range(2));
		return idx_t'({$urandom, $urandom});
	endfunction

	task automatic random_shape();
		logic [2:0] n;
		dim_t s [MAX_DIMS];
		dsel_t red, grw;
		n = 3'($urandom_range(2, 4));
		foreach (s[k]) begin
			case ($urandom_range(5))
				0: s[k] = 12'd4095;
				1: s[k] = 12'd1;
				default: s[k] = dim_t'($urandom_range(1, 40));
			endcase
		end
		if ($urandom_range(19) == 0) s[$urandom_range(MAX_DIMS - 1)] = 12'd0;
		red = dsel_t'($urandom_range(n - 1));
		grw = dsel_t'($urandom_range(n - 1));
		if ($urandom_range(9) != 0) while (grw == red) grw = dsel_t'($urandom_range(n - 1));
		if ($urandom_range(24) == 0) n = 3'($urandom_range(7));
		set_shape(n, s[0], s[1], s[2], s[3], red, grw);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.in_index = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		calm = 1'b0;
		phases = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape has one element only.
		send_index('0);
		send_index(48'd1);
		drain();

		set_shape(3'd4, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 2'd3, 2'd0);
		send_index('0);
		send_index(48'hFFFF_FFFF_FFFF);
		send_index(48'hFFC0_05FF_C000);      // last element: 4095^4 - 1
		send_index(48'hFFC0_05FF_C001);
		send_index(48'h5555_5555_5555);
		send_index(48'hAAAA_AAAA_AAAA);
		drain();
		set_shape(3'd3, 12'd3, 12'd0, 12'd5, 12'd7, 2'd0, 2'd2);   // zero size
		send_index('0);
		drain();
		set_shape(3'd2, 12'd6, 12'd5, 12'd9, 12'd9, 2'd1, 2'd1);   // reduce equals grow
		send_index(48'd3);
		drain();
		set_shape(3'd2, 12'd6, 12'd5, 12'd9, 12'd9, 2'd1, 2'd2);   // grow beyond num_dims
		send_index(48'd3);
		drain();
		set_shape(3'd5, 12'd6, 12'd5, 12'd9, 12'd9, 2'd1, 2'd0);   // too many dims
		send_index(48'd3);
		drain();
		set_shape(3'd1, 12'd6, 12'd5, 12'd9, 12'd9, 2'd1, 2'd0);   // too few dims
		send_index(48'd3);
		drain();
		set_shape(3'd2, 12'd6, 12'd5, 12'd9, 12'd9, 2'd1, 2'd0);
		send_index(48'd29);
		send_index(48'd30);
		send_index(48'd7);
		drain();
		write_reg(3'd7, 12'hFFF);   // unmapped register index, ignored
		send_index(48'd7);
		drain();

		for (int b = 0; b < 30; b++) begin
			calm = (b >= 12 && b < 16);
			random_shape();
			for (int i = 0; i < 20; i++) send_index(pick_index());
			drain();
		end
		calm = 1'b0;

		$display("covered %0d shapes, %0d results checked", phases, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("merge_dimensions_index_remap_unit_tb: done, clean");
		end else begin
			$display("merge_dimensions_index_remap_unit_tb: done, errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/mdr_pkg.sv
rtl/mdr_ifs.sv
rtl/mdr_div_cell.sv
rtl/mdr_mac_cell.sv
rtl/merge_dimensions_index_remap_unit.sv
rtl/mdr_checker.sv
tb/sv/merge_dimensions_index_remap_unit_tb.sv
